FILE: rtl/b64e_pkg.sv
// Shared types, constants and the symbol lookup for the base64 stream encoder.
// No dependencies; every other file in rtl/ but b64e_chan_if refers to it by scoped names.
`default_nettype none

package b64e_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam int unsigned GROUP_CHARS     = 4;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [7:0] ASCII_UC_A = 8'h41;
  localparam logic [7:0] ASCII_LC_A = 8'h61;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_PLUS = 8'h2B;
  localparam logic [7:0] ASCII_SLSH = 8'h2F;

  localparam logic [1:0] CNT_EMPTY = 2'd0;
  localparam logic [1:0] CNT_ONE   = 2'd1;
  localparam logic [1:0] CNT_TWO   = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_item_t;

  // One encoded group of four characters; last marks the fourth as final.
  typedef struct packed {
    logic [GROUP_CHARS-1:0][7:0] chars;
    logic                        last;
  } group_t;

  typedef struct packed {
    logic   valid;
    group_t group;
  } push_t;

  typedef struct packed {
    logic   valid;
    group_t group;
  } head_t;

  function automatic logic [7:0] sym(input logic [5:0] sextet);
    logic [7:0] s;
    s = {2'b00, sextet};
    if (sextet inside {[6'd0:6'd25]}) begin
      return ASCII_UC_A + s;
    end else if (sextet inside {[6'd26:6'd51]}) begin
      return ASCII_LC_A + s - 8'd26;
    end else if (sextet inside {[6'd52:6'd61]}) begin
      return ASCII_ZERO + s - 8'd52;
    end else if (sextet == 6'd62) begin
      return ASCII_PLUS;
    end else begin
      return ASCII_SLSH;
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/b64e_chan_if.sv
// Valid/ready channel interface carrying one payload item per transfer.
// Payload type is a parameter; the encoder uses the item types of b64e_pkg.
`default_nettype none

interface b64e_chan_if #(
  parameter type payload_t = logic [7:0]
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/b64e_front.sv
// Front end: accepts raw bytes, holds a partial group and builds encoded groups.
// Depends on b64e_pkg and b64e_chan_if.
`default_nettype none

module b64e_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  b64e_chan_if.sink          in_ch,
  input  wire logic          q_full,
  output b64e_pkg::push_t    push
);

  logic [15:0] pend_r, pend_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [1:0]  cnt;
  logic        take;
  logic [7:0]  b;
  logic        eom;
  logic [23:0] word;
  logic [7:0]  first;

  assign in_ch.ready = !q_full;
  assign take        = in_ch.valid && in_ch.ready;
  assign b           = in_ch.payload.data_byte;
  assign eom         = in_ch.payload.end_of_message;
  // The unused count code behaves as an empty group.
  assign cnt         = (cnt_r == 2'd3) ? b64e_pkg::CNT_EMPTY : cnt_r;
  assign word        = {pend_r, b};
  assign first       = pend_r[7:0];

  always_comb begin
    pend_nxt         = pend_r;
    cnt_nxt          = cnt_r;
    push.valid       = 1'b0;
    push.group.last  = eom;
    push.group.chars = '0;
    if (cnt == b64e_pkg::CNT_TWO) begin
      push.group.chars[0] = b64e_pkg::sym(word[23:18]);
      push.group.chars[1] = b64e_pkg::sym(word[17:12]);
      push.group.chars[2] = b64e_pkg::sym(word[11:6]);
      push.group.chars[3] = b64e_pkg::sym(word[5:0]);
    end else if (cnt == b64e_pkg::CNT_EMPTY) begin
      push.group.chars[0] = b64e_pkg::sym(b[7:2]);
      push.group.chars[1] = b64e_pkg::sym({b[1:0], 4'b0000});
      push.group.chars[2] = b64e_pkg::PAD_CHAR;
      push.group.chars[3] = b64e_pkg::PAD_CHAR;
    end else begin
      push.group.chars[0] = b64e_pkg::sym(first[7:2]);
      push.group.chars[1] = b64e_pkg::sym({first[1:0], b[7:4]});
      push.group.chars[2] = b64e_pkg::sym({b[3:0], 2'b00});
      push.group.chars[3] = b64e_pkg::PAD_CHAR;
    end

    if (take) begin
      if (cnt == b64e_pkg::CNT_TWO || eom) begin
        push.valid = 1'b1;
        pend_nxt   = '0;
        cnt_nxt    = b64e_pkg::CNT_EMPTY;
      end else begin
        pend_nxt = {pend_r[7:0], b};
        cnt_nxt  = cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      cnt_r  <= b64e_pkg::CNT_EMPTY;
    end else begin
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/b64e_queue.sv
// Short group queue between the front and back ends of the encoder.
// Depends on b64e_pkg for the group types.
`default_nettype none

module b64e_queue #(
  parameter int unsigned DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire b64e_pkg::push_t push,
  input  wire logic            pop,
  output logic                 full,
  output b64e_pkg::head_t      head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  b64e_pkg::group_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full       = (cnt_r == FULL_CNT);
  assign head.valid = (cnt_r != '0);
  assign head.group = mem_r[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.group;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/b64e_back.sv
// Back end: serialises queued groups into single characters on a registered output.
// Depends on b64e_pkg and b64e_chan_if.
`default_nettype none

module b64e_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire b64e_pkg::head_t head,
  output logic                 pop,
  b64e_chan_if.source          out_ch
);

  logic                    out_valid_r, out_valid_nxt;
  b64e_pkg::out_item_t     out_r, out_nxt;
  logic [1:0]              idx_r, idx_nxt;
  logic                    load;

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_r;

  // With a group queued, a new character enters the output register whenever
  // that register is empty or its current transfer completes in this cycle.
  assign load = head.valid && (!out_valid_r || out_ch.ready);
  assign pop  = load && (idx_r == 2'd3);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    idx_nxt       = idx_r;
    if (load) begin
      out_valid_nxt     = 1'b1;
      out_nxt.out_char  = head.group.chars[idx_r];
      out_nxt.last_char = head.group.last && (idx_r == 2'd3);
      idx_nxt           = idx_r + 2'd1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/base64_stream_encoder.sv
// Top level of the streaming base64 encoder (standard alphabet, '=' padding).
// Depends on b64e_pkg, b64e_chan_if, b64e_front, b64e_queue and b64e_back.
`default_nettype none

// Bytes go in one per transfer, with end_of_message set on the last byte of a
// message; each message must hold at least one byte. Characters come out one
// per transfer, and last_char marks the final character of each message. The
// front end takes a byte in every cycle while its group queue has room; the
// first two bytes of a group are only held and produce nothing yet. The third
// byte, or the last byte of a message, turns the group into four characters,
// which the back end sends at one per cycle, while the output channel accepts
// them, through a registered output. The output channel therefore sets the
// sustained rate: any group of one to three bytes gives four characters. The
// queue holds QUEUE_DEPTH groups, letting input run ahead of a stalled output.
module base64_stream_encoder #(
  parameter int unsigned QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
  input wire logic    clk,
  input wire logic    rst_n,
  b64e_chan_if.sink   in_ch,
  b64e_chan_if.source out_ch
);

  b64e_pkg::push_t push;
  b64e_pkg::head_t head;
  logic            q_full;
  logic            pop;

  b64e_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (q_full),
    .head  (head)
  );

  b64e_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire
